FILE: src/tea_block_cipher_assert.svh
// assertion macros for the tea block cipher checker
// no dependencies; include by bare file name inside a module body
`ifndef TEA_BLOCK_CIPHER_ASSERT_SVH
`define TEA_BLOCK_CIPHER_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define TEA_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define TEA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tea_pkg.sv
// types, constants and the round function for the tea block cipher
// no dependencies; imported by every design module of the block
`timescale 1ns / 1ps

package tea_pkg;

  localparam logic [31:0] TEA_DELTA  = 32'h9e37_79b9;
  localparam logic [31:0] TEA_SUM16  = 32'he377_9b90;
  localparam logic [31:0] TEA_SUM32  = 32'hc6ef_3720;
  localparam logic [31:0] TEA_SUM64  = 32'h8dde_6e40;
  localparam logic [3:0]  CHUNK_BYTES = 4'd8;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION   = 3'd0,
    REG_ROUND_COUNT = 3'd1,
    REG_KEY0        = 3'd2,
    REG_KEY1        = 3'd3,
    REG_KEY2        = 3'd4,
    REG_KEY3        = 3'd5
  } tea_reg_t;

  typedef struct packed {
    logic        decrypt;
    logic [6:0]  round_count;
    logic [31:0] key0;
    logic [31:0] key1;
    logic [31:0] key2;
    logic [31:0] key3;
  } tea_cfg_t;

  // one item travelling down the round pipeline
  typedef struct packed {
    logic        valid;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    logic [3:0]  byte_count;
    logic        bypass;
    logic        passed;
  } tea_item_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

  // delta times the round count, for the three legal counts
  function automatic logic [31:0] tea_dec_sum(input logic [6:0] rc);
    logic [31:0] s;
    s = '0;
    case (rc)
      7'd16:   s = TEA_SUM16;
      7'd32:   s = TEA_SUM32;
      7'd64:   s = TEA_SUM64;
      default: s = '0;
    endcase
    tea_dec_sum = s;
  endfunction

endpackage

FILE: src/tea_entry.sv
// entry stage: classifies the chunk and seeds the running sum
// depends on tea_pkg
`timescale 1ns / 1ps

module tea_entry #(
  parameter int MAX_ROUNDS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       in_word_low,
  input  logic [31:0]       in_word_high,
  input  logic [3:0]        in_byte_count,
  input  tea_pkg::tea_cfg_t cfg,
  output tea_pkg::tea_item_t item_o
);
  import tea_pkg::*;

  tea_item_t item_r, item_nxt;
  logic      short_chunk;
  logic      rounds_ok;

  always_comb begin
    short_chunk = in_byte_count < CHUNK_BYTES;
    rounds_ok   = (cfg.round_count == 7'd16 || cfg.round_count == 7'd32 ||
                   cfg.round_count == 7'd64) && (cfg.round_count <= 7'(MAX_ROUNDS));
    item_nxt.valid      = in_valid;
    item_nxt.y          = in_word_low;
    item_nxt.z          = in_word_high;
    item_nxt.sum        = cfg.decrypt ? tea_dec_sum(cfg.round_count) : TEA_DELTA;
    item_nxt.byte_count = short_chunk ? in_byte_count : CHUNK_BYTES;
    item_nxt.bypass     = short_chunk || !rounds_ok;
    item_nxt.passed     = !short_chunk && !rounds_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

FILE: src/tea_half_round.sv
// one half of a tea cycle, one register stage of the round pipeline
// depends on tea_pkg
`timescale 1ns / 1ps

module tea_half_round #(
  parameter int CYCLE = 0,
  parameter bit ODD   = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tea_pkg::tea_cfg_t  cfg,
  input  tea_pkg::tea_item_t item_i,
  output tea_pkg::tea_item_t item_o
);
  import tea_pkg::*;

  localparam logic [6:0] CYC = 7'(CYCLE);

  tea_item_t   item_r, item_nxt;
  logic        active;
  logic [31:0] mix_v;

  always_comb begin
    item_nxt = item_i;
    active   = item_i.valid && !item_i.bypass && (CYC < cfg.round_count);
    // first half works on y when encrypting, on z when decrypting
    if (ODD ^ cfg.decrypt) begin
      mix_v = tea_mix(item_i.y, item_i.sum, cfg.key2, cfg.key3);
    end else begin
      mix_v = tea_mix(item_i.z, item_i.sum, cfg.key0, cfg.key1);
    end
    if (active) begin
      if (!cfg.decrypt) begin
        if (ODD) begin
          item_nxt.z   = item_i.z + mix_v;
          item_nxt.sum = item_i.sum + TEA_DELTA;
        end else begin
          item_nxt.y = item_i.y + mix_v;
        end
      end else begin
        if (ODD) begin
          item_nxt.y   = item_i.y - mix_v;
          item_nxt.sum = item_i.sum - TEA_DELTA;
        end else begin
          item_nxt.z = item_i.z - mix_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

FILE: src/tea_out_skid.sv
// output register with a one-item skid buffer behind it
// depends on tea_pkg; holds the pipeline only when the skid is occupied
`timescale 1ns / 1ps

module tea_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  tea_pkg::tea_item_t item_i,
  output logic               hold,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_low,
  output logic [31:0]        out_high,
  output logic [3:0]         out_byte_count,
  output logic               out_passed_through
);
  import tea_pkg::*;

  tea_item_t out_r, out_nxt;
  tea_item_t skid_r, skid_nxt;
  logic      take;
  logic      out_free;

  always_comb begin
    take     = out_r.valid && !out_stall;
    out_free = !out_r.valid || take;
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (skid_r.valid) begin
      // pipeline is frozen, nothing arrives this cycle
      if (take) begin
        out_nxt        = skid_r;
        skid_nxt.valid = 1'b0;
      end
    end else if (item_i.valid) begin
      if (out_free) begin
        out_nxt = item_i;
      end else begin
        skid_nxt = item_i;
      end
    end else if (take) begin
      out_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      out_r  <= out_nxt;
      skid_r <= skid_nxt;
    end
  end

  assign hold               = skid_r.valid;
  assign out_valid          = out_r.valid;
  assign out_low            = out_r.y;
  assign out_high           = out_r.z;
  assign out_byte_count     = out_r.byte_count;
  assign out_passed_through = out_r.passed;

endmodule

FILE: src/tea_block_cipher.sv
// top level of the tea block cipher: config registers and the round pipeline
// depends on tea_pkg, tea_entry, tea_half_round and tea_out_skid
//
//   channel | handshake             | payload
//   in      | in_valid / in_stall   | in_word_low, in_word_high, in_byte_count
//   out     | out_valid / out_stall | out_low, out_high, out_byte_count, out_passed_through
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; the round pipeline has
// one register stage per half cycle of the round function
// short chunks and bad round counts ride the same stages untouched
// reset clears valids and loads round count 32, encrypt, zero key
// a one-item skid behind the output register keeps the input open while
// a result waits; in_stall rises only once the skid is occupied
`timescale 1ns / 1ps

module tea_block_cipher #(
  parameter int MAX_ROUNDS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_word_low,
  input  logic [31:0]                   in_word_high,
  input  logic [3:0]                    in_byte_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_low,
  output logic [31:0]                   out_high,
  output logic [3:0]                    out_byte_count,
  output logic                          out_passed_through,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import tea_pkg::*;

  localparam int STAGES = 2 * MAX_ROUNDS;

  tea_cfg_t  cfg_r, cfg_nxt;
  tea_item_t pipe [0:STAGES];
  logic      hold;
  logic      en;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIRECTION:   cfg_nxt.decrypt     = cfg_data[0];
        REG_ROUND_COUNT: cfg_nxt.round_count = cfg_data[6:0];
        REG_KEY0:        cfg_nxt.key0        = cfg_data;
        REG_KEY1:        cfg_nxt.key1        = cfg_data;
        REG_KEY2:        cfg_nxt.key2        = cfg_data;
        REG_KEY3:        cfg_nxt.key3        = cfg_data;
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decrypt     <= 1'b0;
      cfg_r.round_count <= 7'd32;
      cfg_r.key0        <= '0;
      cfg_r.key1        <= '0;
      cfg_r.key2        <= '0;
      cfg_r.key3        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign en        = !hold;
  assign in_stall  = hold;

  tea_entry #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_entry (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_word_low   (in_word_low),
    .in_word_high  (in_word_high),
    .in_byte_count (in_byte_count),
    .cfg           (cfg_r),
    .item_o        (pipe[0])
  );

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    tea_half_round #(
      .CYCLE (g / 2),
      .ODD   (1'(g % 2))
    ) u_half (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cfg    (cfg_r),
      .item_i (pipe[g]),
      .item_o (pipe[g+1])
    );
  end

  tea_out_skid u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_i             (en ? pipe[STAGES] : '0),
    .hold               (hold),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_low            (out_low),
    .out_high           (out_high),
    .out_byte_count     (out_byte_count),
    .out_passed_through (out_passed_through)
  );

endmodule

FILE: src/tea_checker.sv
// port-level checker for the tea block cipher, bound to the top level
// depends on tea_block_cipher_assert.svh
`timescale 1ns / 1ps

module tea_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_byte_count,
  input logic       out_passed_through
);
  `include "tea_block_cipher_assert.svh"

  // a stalled result stays offered
  `TEA_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  // input only stalls when a result is waiting
  `TEA_ASSERT_CLK(a_stall_cause, in_stall |-> out_valid, "input stalled with empty output")
  // a pass-through flag only ever comes with a full chunk
  `TEA_ASSERT_CLK(a_pass_full, out_valid && out_passed_through |-> out_byte_count == 4'd8,
                  "pass-through flag on short chunk")
  // reset empties the pipeline and opens the input
  `TEA_ASSERT_RST(a_reset_clear, !rst_n |=> !out_valid && !in_stall, "state left after reset")

endmodule

bind tea_block_cipher tea_checker u_tea_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte_count     (out_byte_count),
  .out_passed_through (out_passed_through)
);

FILE: tb/sv/tea_block_cipher_tb.sv
// self-checking testbench for the tea block cipher: directed chunks, then random bursts
// depends on tea_pkg and tea_block_cipher; predicts each result chunk in its own code
`timescale 1ns / 1ps

module tea_block_cipher_tb;
  import tea_pkg::*;

  localparam int MAX_ROUNDS  = 64;
  localparam int LATENCY     = 2 * MAX_ROUNDS + 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int BURST_ITEMS = 46;

  // indexes past the last register, written to show they change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] low;
    logic [31:0] high;
    logic [3:0]  count;
    logic        passed;
  } chunk_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [31:0]          in_word_low = '0;
  logic [31:0]          in_word_high = '0;
  logic [3:0]           in_byte_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [31:0]          out_low;
  logic [31:0]          out_high;
  logic [3:0]           out_byte_count;
  logic                 out_passed_through;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // shadow of the block's registers, reset values
  logic        sh_decrypt = 1'b0;
  logic [6:0]  sh_rounds = 7'd32;
  logic [31:0] sh_key0 = '0;
  logic [31:0] sh_key1 = '0;
  logic [31:0] sh_key2 = '0;
  logic [31:0] sh_key3 = '0;

  chunk_t pending_chunks[$];
  int     mismatches = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  tea_block_cipher #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_word_low       (in_word_low),
    .in_word_high      (in_word_high),
    .in_byte_count     (in_byte_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_low           (out_low),
    .out_high          (out_high),
    .out_byte_count    (out_byte_count),
    .out_passed_through(out_passed_through),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_chunks.size());
      $display("tea_block_cipher verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [31:0] feistel_term(input logic [31:0] v, input logic [31:0] s,
                                               input logic [31:0] ka, input logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

  function automatic chunk_t predict_chunk(input logic [31:0] lo, input logic [31:0] hi,
                                           input logic [3:0] cnt);
    chunk_t      r;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    int          n;
    r.low    = lo;
    r.high   = hi;
    r.count  = cnt;
    r.passed = 1'b0;
    // tail of a message goes through as given, before any round count check
    if (cnt < CHUNK_BYTES) return r;
    r.count = CHUNK_BYTES;
    if (!(sh_rounds == 7'd16 || sh_rounds == 7'd32 || sh_rounds == 7'd64)) begin
      r.passed = 1'b1;
      return r;
    end
    y = lo;
    z = hi;
    if (!sh_decrypt) begin
      s = '0;
      for (n = 0; n < sh_rounds; n++) begin
        s = s + TEA_DELTA;
        y = y + feistel_term(z, s, sh_key0, sh_key1);
        z = z + feistel_term(y, s, sh_key2, sh_key3);
      end
    end else begin
      s = TEA_DELTA * {25'd0, sh_rounds};
      for (n = 0; n < sh_rounds; n++) begin
        z = z - feistel_term(y, s, sh_key2, sh_key3);
        y = y - feistel_term(z, s, sh_key0, sh_key1);
        s = s - TEA_DELTA;
      end
    end
    r.low  = y;
    r.high = z;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    chunk_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chunks.size() == 0) begin
        report_mismatch("result with nothing pending, low word", out_low, '0);
      end else begin
        want = pending_chunks.pop_front();
        if (out_low !== want.low) report_mismatch("out_low", out_low, want.low);
        if (out_high !== want.high) report_mismatch("out_high", out_high, want.high);
        if (out_byte_count !== want.count)
          report_mismatch("out_byte_count", 32'(out_byte_count), 32'(want.count));
        if (out_passed_through !== want.passed)
          report_mismatch("out_passed_through", 32'(out_passed_through), 32'(want.passed));
      end
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_chunk(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [3:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_word_low   <= lo;
    in_word_high  <= hi;
    in_byte_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_chunks.push_back(predict_chunk(lo, hi, cnt));
    @(negedge clk);
  endtask

  // drop valid and wait for every pending result, so registers may be written
  task automatic finish_burst();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chunks.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DIRECTION:   sh_decrypt = data[0];
      REG_ROUND_COUNT: sh_rounds = data[6:0];
      REG_KEY0:        sh_key0 = data;
      REG_KEY1:        sh_key1 = data;
      REG_KEY2:        sh_key2 = data;
      REG_KEY3:        sh_key3 = data;
      default:         ;
    endcase
    @(negedge clk);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(input logic dir, input logic [6:0] rounds,
                             input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3);
    cfg_write(REG_DIRECTION, {31'd0, dir});
    cfg_write(REG_ROUND_COUNT, {25'd0, rounds});
    cfg_write(REG_KEY0, k0);
    cfg_write(REG_KEY1, k1);
    cfg_write(REG_KEY2, k2);
    cfg_write(REG_KEY3, k3);
    cfg_release();
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] rand_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return CHUNK_BYTES;
    if (pick < 85) return 4'($urandom_range(15, 9));
    return 4'($urandom_range(7));
  endfunction

  function automatic logic [6:0] planned_rounds(input int b);
    case (b)
      0:       return 7'd16;
      1:       return 7'd32;
      2:       return 7'd64;
      3:       return 7'd64;
      4:       return 7'd32;
      5:       return 7'd16;
      6:       return 7'd0;
      default: return 7'd127;
    endcase
  endfunction

  // nothing written yet: encrypt, 32 rounds, zero key
  task automatic test_reset_defaults();
    send_chunk('0, '0, CHUNK_BYTES);
    send_chunk('1, '1, CHUNK_BYTES);
    finish_burst();
  endtask

  // every byte count, short tails, full chunks and oversized counts
  task automatic test_chunk_lengths();
    int c;
    load_config(1'b1, 7'd16, '1, 32'h0123_4567, 32'h89ab_cdef, '0);
    for (c = 0; c < 16; c++) begin
      if (c[0]) send_chunk('1, '0, 4'(c));
      else send_chunk($urandom, '1, 4'(c));
    end
    finish_burst();
  endtask

  task automatic test_spare_registers();
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, '1);
    cfg_release();
    send_chunk(32'hdead_beef, 32'h0bad_f00d, CHUNK_BYTES);
    send_chunk('0, '1, CHUNK_BYTES);
    finish_burst();
  endtask

  // largest legal count both ways, and counts either side of the legal set
  task automatic test_round_limits();
    load_config(1'b1, 7'd64, '1, '1, '1, '1);
    send_chunk('1, '0, CHUNK_BYTES);
    finish_burst();
    load_config(1'b0, 7'd64, '1, '1, '1, '1);
    send_chunk('0, '1, CHUNK_BYTES);
    finish_burst();
    load_config(1'b0, 7'd65, $urandom, $urandom, $urandom, $urandom);
    send_chunk($urandom, $urandom, CHUNK_BYTES);
    finish_burst();
    load_config(1'b1, 7'd0, $urandom, $urandom, $urandom, $urandom);
    send_chunk($urandom, $urandom, 4'd15);
    finish_burst();
  endtask

  task automatic test_random_traffic(input int mode);
    int         b;
    int         n;
    logic [6:0] rounds;
    for (b = 0; b < 8; b++) begin
      if (mode == 2 && b == 7) rounds = 7'($urandom_range(127));
      else rounds = planned_rounds(b);
      load_config(1'((b + mode) & 1), rounds, rand_word(), rand_word(), rand_word(),
                  rand_word());
      for (n = 0; n < BURST_ITEMS; n++) send_chunk(rand_word(), rand_word(), rand_count());
      finish_burst();
    end
  endtask

  initial begin
    int mode;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 35;
    recv_stall_pct = 60;
    test_reset_defaults();
    test_chunk_lengths();
    test_spare_registers();
    test_round_limits();
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 35;
          recv_stall_pct = 60;
        end
        1: begin
          send_idle_pct  = 60;
          recv_stall_pct = 35;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      test_random_traffic(mode);
    end
    // catch anything that comes out late
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_chunks.size() == 0) begin
      $display("tea_block_cipher verification clean");
    end else begin
      $display("tea_block_cipher verification failed");
    end
    $finish;
  end

endmodule
